// File: rtl/htfd_pkg.sv
// package for the humidity / temperature frame decoder
// holds the shared types, codes, conversion constants and the crc-8 step
// no dependencies
`timescale 1ns / 1ps

package htfd_pkg;

    // crc-8 polynomial 0x131 without its top bit
    localparam logic [7:0]  CRC_POLY_LOW = 8'h31;
    // the two low bits of the word are sensor status bits
    localparam logic [15:0] STATUS_MASK  = 16'hFFFC;
    // bit of the word that marks a humidity reading
    localparam int          KIND_BIT     = 1;

    // gains scaled by 100, applied as gain * w / 65536
    localparam logic [14:0] TEMP_GAIN    = 15'd17572;
    localparam logic [14:0] HUM_GAIN     = 15'd12500;
    // offsets in hundredths
    localparam logic signed [15:0] TEMP_OFFSET = -16'sd4685;
    localparam logic signed [15:0] HUM_OFFSET  = -16'sd600;

    // expected reading type
    localparam logic KIND_TEMP = 1'b0;
    localparam logic KIND_HUM  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CRC_ERR  = 2'd1,
        ST_KIND_ERR = 2'd2
    } t_status;

    // byte position inside a frame
    typedef enum logic [1:0] {
        POS_HIGH  = 2'd0,
        POS_LOW   = 2'd1,
        POS_CHECK = 2'd2
    } t_pos;

    // one decoded frame on its way to the conversion side
    typedef struct packed {
        logic [15:0] raw_word;
        logic        kind;
        t_status     status;
    } t_frame;

    // one byte of crc-8, msb first, no reflection
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY_LOW;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/htfd_if.sv
// valid / ready channel interfaces for the frame decoder
// input channel carries one byte item, output channel one decoded reading
// no dependencies
`timescale 1ns / 1ps

interface htfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       measure_kind;

    modport source (output valid, output data_byte, output measure_kind, input ready);
    modport sink   (input valid, input data_byte, input measure_kind, output ready);
endinterface

interface htfd_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        raw_word;
    logic signed [14:0] reading_centi;
    logic [1:0]         status;

    modport source (output valid, output raw_word, output reading_centi, output status,
                    input ready);
    modport sink   (input valid, input raw_word, input reading_centi, input status,
                    output ready);
endinterface

// File: rtl/htfd_front.sv
// front end: takes byte items, tracks frame position, runs the crc
// and classifies the frame on its checksum byte; uses htfd_pkg, htfd_if
`timescale 1ns / 1ps

module htfd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    htfd_in_if.sink          i_in,
    input  logic             i_full,
    output logic             o_push,
    output htfd_pkg::t_frame o_frame
);
    import htfd_pkg::*;

    t_pos        r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_word, n_word;
    logic        accept;

    // data bytes never need queue room, only the checksum byte does
    always_comb begin
        i_in.ready = (r_pos == POS_HIGH) || (r_pos == POS_LOW) || !i_full;
    end

    assign accept = i_in.valid && i_in.ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_HIGH;
            r_crc  <= 8'h00;
            r_word <= 16'h0000;
        end else begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_word <= n_word;
        end
    end

    // next state and frame classification
    always_comb begin
        n_pos            = r_pos;
        n_crc            = r_crc;
        n_word           = r_word;
        o_push           = 1'b0;
        o_frame.raw_word = r_word & STATUS_MASK;
        o_frame.kind     = i_in.measure_kind;
        if (r_crc != i_in.data_byte) begin
            o_frame.status = ST_CRC_ERR;
        end else if (r_word[KIND_BIT] != i_in.measure_kind) begin
            o_frame.status = ST_KIND_ERR;
        end else begin
            o_frame.status = ST_OK;
        end
        case (r_pos)
            POS_HIGH: begin
                if (accept) begin
                    n_word = {i_in.data_byte, 8'h00};
                    n_crc  = crc8_update(8'h00, i_in.data_byte);
                    n_pos  = POS_LOW;
                end
            end
            POS_LOW: begin
                if (accept) begin
                    n_word = {r_word[15:8], i_in.data_byte};
                    n_crc  = crc8_update(r_crc, i_in.data_byte);
                    n_pos  = POS_CHECK;
                end
            end
            default: begin
                // checksum byte, also taken for the unused position code
                if (accept) begin
                    o_push = 1'b1;
                    n_pos  = POS_HIGH;
                    n_crc  = 8'h00;
                    n_word = 16'h0000;
                end
            end
        endcase
    end

`ifndef SYNTHESIS
    a_push_restarts_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_pos == POS_HIGH) && (r_crc == 8'h00) && (r_word == 16'h0000))
        else $error("frame state not cleared after checksum byte");
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_push && i_full))
        else $error("frame pushed into a full queue");
    a_low_after_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (r_pos == POS_HIGH)) |=> (r_pos == POS_LOW))
        else $error("high byte did not advance the position");
`endif

endmodule

// File: rtl/htfd_fifo.sv
// short queue of decoded frames between front end and conversion side
// register based, first in first out; uses htfd_pkg
`timescale 1ns / 1ps

module htfd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  htfd_pkg::t_frame i_frame,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output htfd_pkg::t_frame o_frame
);
    import htfd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_frame             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_frame = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count above depth");
    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_valid) |=> (r_count == $past(r_count) + (CNT_W'($past(do_push)))))
        else $error("pop from empty queue changed the count");
    a_push_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> o_valid)
        else $error("pushed frame not visible");
`endif

endmodule

// File: rtl/htfd_back.sv
// conversion side: pops decoded frames, scales the word with one
// multiplier stage and an output register stage; uses htfd_pkg, htfd_if
`timescale 1ns / 1ps

module htfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  htfd_pkg::t_frame i_frame,
    output logic             o_pop,
    htfd_out_if.source       o_out
);
    import htfd_pkg::*;

    // multiply stage
    logic               r_a_valid;
    logic [15:0]        r_a_word;
    logic               r_a_kind;
    t_status            r_a_status;
    logic [30:0]        r_a_prod;
    // output stage
    logic               r_b_valid;
    logic [15:0]        r_b_word;
    logic signed [14:0] r_b_reading;
    t_status            r_b_status;

    logic               b_ready, a_ready;
    logic [14:0]        gain;
    logic signed [15:0] offset, sum;

    assign b_ready = !r_b_valid || o_out.ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_pop   = i_valid && a_ready;

    assign gain   = (i_frame.kind == KIND_HUM) ? HUM_GAIN : TEMP_GAIN;
    assign offset = (r_a_kind == KIND_HUM) ? HUM_OFFSET : TEMP_OFFSET;
    assign sum    = offset + $signed({1'b0, r_a_prod[30:16]});

    // multiply stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
        if (o_pop) begin
            r_a_word   <= i_frame.raw_word;
            r_a_kind   <= i_frame.kind;
            r_a_status <= i_frame.status;
            r_a_prod   <= 31'(gain * i_frame.raw_word);
        end
    end

    // output registers, reading forced to zero on any error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
        if (b_ready && r_a_valid) begin
            r_b_word    <= r_a_word;
            r_b_status  <= r_a_status;
            r_b_reading <= (r_a_status == ST_OK) ? sum[14:0] : 15'sd0;
        end
    end

    assign o_out.valid         = r_b_valid;
    assign o_out.raw_word      = r_b_word;
    assign o_out.reading_centi = r_b_reading;
    assign o_out.status        = r_b_status;

`ifndef SYNTHESIS
    a_error_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && (r_b_status != ST_OK)) |-> (r_b_reading == 15'sd0))
        else $error("error result with nonzero reading");
    a_status_bits_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_b_word[1:0] == 2'b00))
        else $error("status bits not cleared in output word");
    a_stage_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && b_ready) |=> r_b_valid)
        else $error("multiply stage result lost");
`endif

endmodule

// File: rtl/humidity_temp_frame_decoder.sv
// Measurement frame decoder for a humidity / temperature sensor.
// Input channel i_in: one item per received byte (high data byte, low data
//   byte, checksum byte) with measure_kind, 0 temperature, 1 humidity; the
//   kind is taken from the checksum byte item.
// Output channel o_out: one item per frame, carrying the word with its two
//   status bits cleared, the reading in hundredths (floored) and a status
//   code: 0 ok, 1 crc-8 mismatch, 2 reading type mismatch. On any error the
//   reading is zero.
// Throughput: one byte item per cycle while the queue has room. The crc-8 byte step is
//   unrolled in the front end; the conversion uses one multiplier stage.
// Result path: the frame is written into the queue when its checksum byte
//   is accepted, then passes the multiply stage and then the output
//   register, which drives o_out.valid.
// Reset (synchronous, active low) returns the frame to its high byte,
//   clears the crc and empties the queue and pipeline.
// Receiver stall: the output register holds its item; data bytes are
//   still accepted, checksum bytes wait once the FIFO_DEPTH queue is full.
// Depends on htfd_pkg, htfd_if, htfd_front, htfd_fifo, htfd_back.
`timescale 1ns / 1ps

module humidity_temp_frame_decoder #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    htfd_in_if.sink    i_in,
    htfd_out_if.source o_out
);
    import htfd_pkg::*;

    logic   push, full, pop, q_valid;
    t_frame push_frame, pop_frame;

    // byte tracking and frame classification
    htfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_frame (push_frame)
    );

    // decoupling queue
    htfd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_frame (pop_frame)
    );

    // conversion and output register
    htfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_frame (pop_frame),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
